// ===== design/gmd_pkg.sv =====
// shared types, constants and helpers of the 3x3 grid max dilation block
package gmd_pkg;

  // fixed field widths
  localparam int SAMPLE_W  = 32;
  localparam int VAL_W     = 31;
  localparam int COORD_W   = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // default maximum grid dimensions; the width also sets the line memory depth
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // reset value of both grid dimensions
  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(16);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

  // result queue sizing
  localparam int MAX_RES    = 4;
  localparam int FIFO_DEPTH = 16;

  // one result item
  typedef struct packed {
    logic [VAL_W-1:0]   dilated;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               last_point;
  } result_t;

  // results of one sample, in emission order, handed to the queue
  typedef struct packed {
    logic [MAX_RES-1:0]  valid;
    result_t [MAX_RES-1:0] item;
  } push_t;

  // unsigned maximum
  function automatic logic [VAL_W-1:0] vmax(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== design/gmd_channels.sv =====
// valid/ready channel interfaces for samples and results
interface gmd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [gmd_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface gmd_out_if;
  logic                         valid;
  logic                         ready;
  logic [gmd_pkg::VAL_W-1:0]    dilated;
  logic [gmd_pkg::COORD_W-1:0]  out_row;
  logic [gmd_pkg::COORD_W-1:0]  out_col;
  logic                         last_point;

  modport source (output valid, output dilated, output out_row, output out_col,
                  output last_point, input ready);
  modport sink (input valid, input dilated, input out_row, input out_col,
                input last_point, output ready);
endinterface

// ===== design/gmd_ram.sv =====
// generic single-write, single-read ram with registered read data
module gmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/gmd_result_fifo.sv =====
// result queue: takes up to four results per cycle, hands out one per transfer
module gmd_result_fifo (
  input  logic           clk,
  input  logic           rst,
  input  gmd_pkg::push_t push,
  output logic           room,
  gmd_out_if.source      out_ch
);

  localparam int PW = $clog2(gmd_pkg::FIFO_DEPTH);
  localparam int CNT_W = PW + 1;
  localparam int OFF_W = $clog2(gmd_pkg::MAX_RES + 1);

  gmd_pkg::result_t mem [gmd_pkg::FIFO_DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [OFF_W-1:0] offs [gmd_pkg::MAX_RES];
  logic [OFF_W-1:0] npush;
  logic             pop;

  // compact the valid results onto consecutive slots
  always_comb begin
    npush = '0;
    for (int i = 0; i < gmd_pkg::MAX_RES; i++) begin
      offs[i] = npush;
      npush = npush + OFF_W'(push.valid[i]);
    end
  end

  assign pop = out_ch.valid && out_ch.ready;
  assign count_next = count + CNT_W'(npush) - CNT_W'(pop);

  // room for the results of two more samples
  assign room = (count <= CNT_W'(gmd_pkg::FIFO_DEPTH - 2 * gmd_pkg::MAX_RES));

  // queue storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < gmd_pkg::MAX_RES; i++) begin
      if (push.valid[i]) begin
        mem[wp + PW'(offs[i])] <= push.item[i];
      end
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + PW'(npush);
      if (pop) begin
        rp <= rp + PW'(1);
      end
      count <= count_next;
    end
  end

  // head of queue drives the output channel
  assign out_ch.valid      = (count != '0);
  assign out_ch.dilated    = mem[rp].dilated;
  assign out_ch.out_row    = mem[rp].out_row;
  assign out_ch.out_col    = mem[rp].out_col;
  assign out_ch.last_point = mem[rp].last_point;

endmodule

// ===== design/grid_max_dilation_3x3.sv =====
// top level of the streaming 3x3 grid max dilation block
// Samples enter in raster order, one per transfer, and each result carries the
// zero-floored maximum of its edge-clamped 3x3 window with its row and column.
// A sample is taken every cycle while the result queue has room: its column
// entry of the two line memories is read in the cycle it is accepted, and
// updated and written back in the next, so one sample costs one read and one
// write on each memory. A sample's results (none to four) pass from the second
// stage into a 16-entry result queue and leave at one per transfer; on the
// bottom row a sample makes two results, so there the output port sets the pace
// once the queue fills. The line memories need no clearing pass after reset. A
// write to either grid dimension restarts the grid at row 0, column 0.
module grid_max_dilation_3x3 #(
  parameter int MAX_WIDTH  = gmd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gmd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gmd_pkg::CFG_W-1:0]     cfg_data,
  gmd_in_if.sink                        in_ch,
  gmd_out_if.source                     out_ch
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CNT_MAX_W = (CW > RW) ? CW : RW;
  localparam int CMP_W = ((CNT_MAX_W > gmd_pkg::CFG_W) ? CNT_MAX_W : gmd_pkg::CFG_W) + 2;
  localparam int VW = gmd_pkg::VAL_W;

  // configuration
  logic [gmd_pkg::CFG_W-1:0] grid_width;
  logic [gmd_pkg::CFG_W-1:0] grid_height;
  logic                      restart;

  // raster position of the next sample
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          col_wrap;
  logic          row_wrap;
  logic          accept;

  // second stage
  logic          s1_valid;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic [VW-1:0] s1_samp;
  logic          s1_fwd;
  logic          s1_top;
  logic          s1_bot;
  logic          s1_right;

  // last values written back, for a read of the same column in the cycle of the write
  logic [VW-1:0] fwd_prev;
  logic [VW-1:0] fwd_pair;

  // column maxima of the last two columns
  logic [VW-1:0] hu0, hu1, hl0, hl1;

  logic [VW-1:0] prev_rdata;
  logic [VW-1:0] pair_rdata;
  logic [VW-1:0] prev_val;
  logic [VW-1:0] pair_val;
  logic [VW-1:0] upper;
  logic [VW-1:0] lower;
  logic [VW-1:0] samp_floor;
  logic          c_ge1;
  logic          c_ge2;
  logic [gmd_pkg::COORD_W-1:0] row_cur;
  logic [gmd_pkg::COORD_W-1:0] row_above;
  logic [gmd_pkg::COORD_W-1:0] col_cur;
  logic [gmd_pkg::COORD_W-1:0] col_left;

  gmd_pkg::push_t push;
  logic           room;

  // register writes, clamped to 1..max
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= gmd_pkg::DIM_RESET;
      grid_height <= gmd_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gmd_pkg::REG_GRID_WIDTH: begin
          if (cfg_data == '0) begin
            grid_width <= gmd_pkg::CFG_W'(1);
          end else if (CMP_W'(cfg_data) > CMP_W'(MAX_WIDTH)) begin
            grid_width <= gmd_pkg::CFG_W'(MAX_WIDTH);
          end else begin
            grid_width <= cfg_data;
          end
        end
        gmd_pkg::REG_GRID_HEIGHT: begin
          if (cfg_data == '0) begin
            grid_height <= gmd_pkg::CFG_W'(1);
          end else if (CMP_W'(cfg_data) > CMP_W'(MAX_HEIGHT)) begin
            grid_height <= gmd_pkg::CFG_W'(MAX_HEIGHT);
          end else begin
            grid_height <= cfg_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign restart = cfg_we && ((cfg_index == gmd_pkg::REG_GRID_WIDTH) ||
                              (cfg_index == gmd_pkg::REG_GRID_HEIGHT));

  // input handshake
  assign in_ch.ready = room;
  assign accept = in_ch.valid && in_ch.ready;

  assign col_wrap = (CMP_W'(col) + CMP_W'(1)) >= CMP_W'(grid_width);
  assign row_wrap = (CMP_W'(row) + CMP_W'(1)) >= CMP_W'(grid_height);

  // raster counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // first stage: memories are read at the current column on every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col;
      s1_row   <= row;
      s1_samp  <= in_ch.sample[gmd_pkg::SAMPLE_W-1] ? '0 : in_ch.sample[VW-1:0];
      s1_fwd   <= s1_valid && (s1_col == col);
      s1_top   <= (row == '0);
      s1_bot   <= row_wrap;
      s1_right <= col_wrap;
    end
  end

  gmd_ram #(.WIDTH(VW), .DEPTH(MAX_WIDTH)) u_prev_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (s1_samp),
    .raddr (col),
    .rdata (prev_rdata)
  );

  gmd_ram #(.WIDTH(VW), .DEPTH(MAX_WIDTH)) u_pair_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (lower),
    .raddr (col),
    .rdata (pair_rdata)
  );

  // second stage: column maxima of the row above and of this row
  assign samp_floor = s1_samp;
  assign prev_val = s1_fwd ? fwd_prev : prev_rdata;
  assign pair_val = s1_fwd ? fwd_pair : pair_rdata;
  assign upper = s1_top ? samp_floor : gmd_pkg::vmax(pair_val, samp_floor);
  assign lower = s1_top ? samp_floor : gmd_pkg::vmax(prev_val, samp_floor);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fwd_prev <= samp_floor;
      fwd_pair <= lower;
    end
  end

  // column histories shift once per sample
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      hu0 <= '0;
      hu1 <= '0;
      hl0 <= '0;
      hl1 <= '0;
    end else if (s1_valid) begin
      hu1 <= hu0;
      hu0 <= upper;
      hl1 <= hl0;
      hl0 <= lower;
    end
  end

  assign c_ge1 = (s1_col != '0);
  assign c_ge2 = CMP_W'(s1_col) >= CMP_W'(2);
  assign row_cur   = gmd_pkg::COORD_W'(s1_row);
  assign row_above = gmd_pkg::COORD_W'(s1_row - RW'(1));
  assign col_cur   = gmd_pkg::COORD_W'(s1_col);
  assign col_left  = gmd_pkg::COORD_W'(s1_col - CW'(1));

  // results in order: row above left and right, then this row left and right
  always_comb begin
    push.valid[0] = s1_valid && !s1_top && c_ge1;
    push.item[0].dilated    = gmd_pkg::vmax(upper, gmd_pkg::vmax(hu0, c_ge2 ? hu1 : '0));
    push.item[0].out_row    = row_above;
    push.item[0].out_col    = col_left;
    push.item[0].last_point = 1'b0;

    push.valid[1] = s1_valid && !s1_top && s1_right;
    push.item[1].dilated    = gmd_pkg::vmax(upper, c_ge1 ? hu0 : '0);
    push.item[1].out_row    = row_above;
    push.item[1].out_col    = col_cur;
    push.item[1].last_point = 1'b0;

    push.valid[2] = s1_valid && s1_bot && c_ge1;
    push.item[2].dilated    = gmd_pkg::vmax(lower, gmd_pkg::vmax(hl0, c_ge2 ? hl1 : '0));
    push.item[2].out_row    = row_cur;
    push.item[2].out_col    = col_left;
    push.item[2].last_point = 1'b0;

    // bottom row, rightmost column: the final grid point
    push.valid[3] = s1_valid && s1_bot && s1_right;
    push.item[3].dilated    = gmd_pkg::vmax(lower, c_ge1 ? hl0 : '0);
    push.item[3].out_row    = row_cur;
    push.item[3].out_col    = col_cur;
    push.item[3].last_point = 1'b1;
  end

  gmd_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

// ===== design/gmd_checker.sv =====
// port-level checks of the dilation block, bound to its top level
module gmd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gmd_pkg::VAL_W-1:0]     dilated,
  input logic [gmd_pkg::COORD_W-1:0]   out_row,
  input logic [gmd_pkg::COORD_W-1:0]   out_col,
  input logic                          last_point
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // a waiting result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({dilated, out_row, out_col, last_point}))
    else $error("result payload changed while stalled");

  // reset empties the result queue and opens the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("queue not empty after reset");

  // the input closes only while results are backed up
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind grid_max_dilation_3x3 gmd_checker u_gmd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .dilated    (out_ch.dilated),
  .out_row    (out_ch.out_row),
  .out_col    (out_ch.out_col),
  .last_point (out_ch.last_point)
);
